// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the top-level RTL file of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Clocked property, disabled while reset is asserted (active low).
`define MTSP_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
	else $error("assertion failed");
// Clocked property, checked in and out of reset.
`define MTSP_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
	else $error("assertion failed");
`else
`define MTSP_ASSERT(lbl, clk, rstn, prop)
`define MTSP_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== design/mtsp_pkg.sv =====
// ----------------------------------------------------------------------------
// mtsp_pkg
// Types, widths and constants of the magnetic track steering PID unit.
// ----------------------------------------------------------------------------
package mtsp_pkg;

	localparam int SAMPLE_BITS = 12;
	localparam int FRAC_BITS   = 16;

	localparam int RATIO_W     = FRAC_BITS + 1;
	localparam int LEVEL_W     = FRAC_BITS + 7;
	localparam int ROOT_W      = (LEVEL_W + FRAC_BITS + 1) / 2;
	localparam int SQ_W        = 2 * ROOT_W;
	localparam int MAG_W       = ROOT_W + 9;
	localparam int SRC_W       = MAG_W + FRAC_BITS;
	localparam int SUM_W       = LEVEL_W + 2;
	localparam int CSU_W       = SUM_W + 1;
	localparam int QUO_W       = 27;
	localparam int ERR_W       = 26;
	localparam int DRIVE_W     = 27;
	localparam int ESUM_W      = 48;
	localparam int ACC_W       = 64;
	localparam int GAIN_W      = 16;
	localparam int STEP_W      = 6;
	localparam int ADDR_W      = 4;
	localparam int LVL_OUT_W   = 7;

	localparam int RATIO_STEPS = FRAC_BITS;
	localparam int EDIV_STEPS  = SRC_W;

	localparam int ONE_Q       = 1 << FRAC_BITS;
	localparam int RATIO_MIN   = (ONE_Q + 500) / 1000;
	localparam logic [LEVEL_W-1:0] LEVEL_ONE = LEVEL_W'(100 * ONE_Q);

	localparam logic signed [ERR_W-1:0]   ERR_MAX   = {1'b0, {(ERR_W-1){1'b1}}};
	localparam logic signed [ERR_W-1:0]   ERR_MIN   = {1'b1, {(ERR_W-1){1'b0}}};
	localparam logic [QUO_W-1:0]          ERR_LIM   = QUO_W'(1) << (ERR_W - 1);
	localparam logic signed [DRIVE_W-1:0] DRIVE_LIM = DRIVE_W'(1000 * ONE_Q);
	localparam logic signed [ESUM_W-1:0]  ESUM_MAX  = {1'b0, {(ESUM_W-1){1'b1}}};
	localparam logic signed [ESUM_W-1:0]  ESUM_MIN  = {1'b1, {(ESUM_W-1){1'b0}}};

	// register indexes on the configuration port
	localparam logic [1:0] REG_GAIN_P = 2'd0;
	localparam logic [1:0] REG_GAIN_I = 2'd1;
	localparam logic [1:0] REG_GAIN_D = 2'd2;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_CAL   = 8'b0000_0010,
		ST_RATIO = 8'b0000_0100,
		ST_SQRT  = 8'b0000_1000,
		ST_EDIV  = 8'b0001_0000,
		ST_PID   = 8'b0010_0000,
		ST_MAC   = 8'b0100_0000,
		ST_FIN   = 8'b1000_0000
	} state_t;

	typedef struct packed {
		logic [CSU_W-1:0] a;
		logic [CSU_W-1:0] b;
	} csu_req_t;

	typedef struct packed {
		logic             ge;
		logic [CSU_W-1:0] diff;
	} csu_rsp_t;

	// clamp a ratio to its floor and scale to the level format
	function automatic logic [LEVEL_W-1:0] level_of(input logic [RATIO_W-1:0] r);
		logic [RATIO_W-1:0] c;
		c = (r < RATIO_W'(RATIO_MIN)) ? RATIO_W'(RATIO_MIN) : r;
		return LEVEL_W'(c) * LEVEL_W'(100);
	endfunction

endpackage

// ===== design/mtsp_csu.sv =====
// ----------------------------------------------------------------------------
// mtsp_csu
// Shared compare-subtract unit for restoring division and square root steps.
// ----------------------------------------------------------------------------
module mtsp_csu (
	input  mtsp_pkg::csu_req_t req,
	output mtsp_pkg::csu_rsp_t rsp
);
	import mtsp_pkg::*;

	logic [CSU_W:0] d;

	assign d        = {1'b0, req.a} - {1'b0, req.b};
	assign rsp.ge   = ~d[CSU_W];
	assign rsp.diff = d[CSU_W-1:0];

endmodule

// ===== design/mtsp_mac.sv =====
// ----------------------------------------------------------------------------
// mtsp_mac
// Bit-serial multiply-accumulate step: one gain bit per cycle, sign bit
// weighted negative.
// ----------------------------------------------------------------------------
module mtsp_mac (
	input  logic signed [mtsp_pkg::ACC_W-1:0]  acc,
	input  logic signed [mtsp_pkg::ACC_W-1:0]  op,
	input  logic        [mtsp_pkg::GAIN_W-1:0] gain,
	input  logic        [3:0]                  bit_idx,
	output logic signed [mtsp_pkg::ACC_W-1:0]  acc_next
);
	import mtsp_pkg::*;

	logic signed [ACC_W-1:0] term;

	assign term = op <<< bit_idx;

	always_comb begin
		if (!gain[bit_idx]) begin
			acc_next = acc;
		end else if (bit_idx == 4'(GAIN_W - 1)) begin
			acc_next = acc - term;
		end else begin
			acc_next = acc + term;
		end
	end

endmodule

// ===== design/magnetic_track_steering_pid_unit.sv =====
// ----------------------------------------------------------------------------
// magnetic_track_steering_pid_unit
// Coil normalization, difference-ratio steering error and positional PID.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                           transfer
//  s_axis    in   tdata: raw_left/center/right, tuser: flags        tvalid&tready
//  m_axis    out  tdata: levels, steering_error, drive              tvalid&tready
//  apb       in   gain_p / gain_i / gain_d at 0x0 / 0x4 / 0x8       psel&penable
//
//  One item runs from transfer to result through calibration, ratio division
//  for each of the three channels, square root of the left and right levels,
//  error division (all on the shared compare-subtract unit), serial
//  multiply-accumulate and finish.
//  A saturated ratio skips its division; control off skips the PID steps.
//  Input is taken only in idle; a waiting result sits in the output register
//  and does not block the next transfer, but finish holds until it is taken.
//  Reset clears gains, maxima, integrator and arms calibration.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module magnetic_track_steering_pid_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// raw_left[11:0], raw_center[23:12], raw_right[35:24], zero pad
	input  logic [39:0] s_axis_tdata,
	// calibrate[0], control_enable[1]
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// level_left[6:0], level_center[13:7], level_right[20:14],
	// steering_error[46:21], drive[73:47], zero pad
	output logic [79:0] m_axis_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [mtsp_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import mtsp_pkg::*;

	state_t state_q;
	logic [STEP_W-1:0]       step_q;
	logic [1:0]              ch_q;
	logic [SAMPLE_BITS-1:0]  raw_q [3];
	logic [SAMPLE_BITS-1:0]  max_q [3];
	logic                    cal_q;
	logic                    en_q;
	logic                    armed_q;
	logic [LEVEL_W-1:0]      level_q [3];
	logic [ROOT_W-1:0]       root_q [2];
	logic [CSU_W-1:0]        rem_q;
	logic [QUO_W-1:0]        quo_q;
	logic                    ovf_q;
	logic [SRC_W-1:0]        src_q;
	logic [SUM_W-1:0]        sum_q;
	logic signed [ERR_W-1:0] err_q;
	logic signed [ERR_W-1:0] elast_q;
	logic signed [ESUM_W-1:0] esum_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [GAIN_W-1:0]       gain_p_q;
	logic [GAIN_W-1:0]       gain_i_q;
	logic [GAIN_W-1:0]       gain_d_q;
	logic                    out_valid_q;
	logic [LVL_OUT_W-1:0]    lvl_out_q [3];
	logic signed [ERR_W-1:0] err_out_q;
	logic signed [DRIVE_W-1:0] drive_q;

	csu_req_t csu_req;
	csu_rsp_t csu_rsp;
	logic [CSU_W-1:0]        rem_next;
	logic [QUO_W-1:0]        quo_next;
	logic                    ovf_next;
	logic signed [ERR_W-1:0] err_next;
	logic [ROOT_W-1:0]       rdiff;
	logic [MAG_W-1:0]        mag;
	logic [SQ_W-1:0]         sq_in;
	logic signed [ESUM_W:0]  esum_add;
	logic signed [ESUM_W-1:0] esum_next;
	logic signed [ACC_W-1:0] mac_op;
	logic [GAIN_W-1:0]       mac_gain;
	logic signed [ACC_W-1:0] mac_next;
	logic signed [ACC_W-1:0] acc_mag;
	logic signed [ACC_W-1:0] acc_shr;
	logic signed [DRIVE_W-1:0] drive_next;
	logic                    fin_load;
	logic                    cfg_wr;

	// ---------------------------------------------------------------- config
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q <= '0;
			gain_i_q <= '0;
			gain_d_q <= '0;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_GAIN_P: gain_p_q <= pwdata[GAIN_W-1:0];
				REG_GAIN_I: gain_i_q <= pwdata[GAIN_W-1:0];
				REG_GAIN_D: gain_d_q <= pwdata[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_GAIN_P: prdata = 32'(signed'(gain_p_q));
			REG_GAIN_I: prdata = 32'(signed'(gain_i_q));
			REG_GAIN_D: prdata = 32'(signed'(gain_d_q));
			default:    prdata = '0;
		endcase
	end

	// ---------------------------------------------------------- shared unit
	// Feed the compare-subtract unit: shift the partial remainder, bring in
	// the next dividend bit or radicand pair, and compare with the divisor
	// or the trial root.
	always_comb begin
		case (state_q)
			ST_RATIO: begin
				csu_req.a = {rem_q[CSU_W-2:0], 1'b0};
				csu_req.b = CSU_W'(max_q[ch_q]);
			end
			ST_SQRT: begin
				csu_req.a = {rem_q[CSU_W-3:0], src_q[SRC_W-1 -: 2]};
				csu_req.b = CSU_W'({quo_q[ROOT_W-1:0], 2'b01});
			end
			ST_EDIV: begin
				csu_req.a = {rem_q[CSU_W-2:0], src_q[SRC_W-1]};
				csu_req.b = CSU_W'(sum_q);
			end
			default: begin
				csu_req.a = '0;
				csu_req.b = '0;
			end
		endcase
	end

	mtsp_csu u_csu (
		.req (csu_req),
		.rsp (csu_rsp)
	);

	assign rem_next = csu_rsp.ge ? csu_rsp.diff : csu_req.a;
	assign quo_next = {quo_q[QUO_W-2:0], csu_rsp.ge};
	assign ovf_next = ovf_q | quo_q[QUO_W-1];

	// Give the final quotient the sign of the root difference and saturate it into the signed error range.
	always_comb begin
		if (root_q[1] > root_q[0]) begin
			err_next = (ovf_next || quo_next > ERR_LIM) ? ERR_MIN
				: -ERR_W'(quo_next);
		end else begin
			err_next = (ovf_next || quo_next >= ERR_LIM) ? ERR_MAX
				: ERR_W'(quo_next);
		end
	end

	// Error division setup: magnitude of the root difference times 500.
	assign rdiff = (root_q[1] > root_q[0]) ? root_q[1] - root_q[0] : root_q[0] - root_q[1];
	assign mag   = MAG_W'(rdiff) * MAG_W'(500);
	assign sq_in = SQ_W'({(ch_q == 2'd0) ? level_q[0] : level_q[2], {FRAC_BITS{1'b0}}});

	// Integrator with saturation at the signed range.
	assign esum_add = (ESUM_W + 1)'(esum_q) + (ESUM_W + 1)'(err_q);
	always_comb begin
		if (esum_add[ESUM_W] != esum_add[ESUM_W-1]) begin
			esum_next = esum_add[ESUM_W] ? ESUM_MIN : ESUM_MAX;
		end else begin
			esum_next = esum_add[ESUM_W-1:0];
		end
	end

	// ------------------------------------------------------------- PID mac
	always_comb begin
		case (ch_q)
			2'd0: begin
				mac_op   = ACC_W'(err_q);
				mac_gain = gain_p_q;
			end
			2'd1: begin
				mac_op   = ACC_W'(esum_q);
				mac_gain = gain_i_q;
			end
			default: begin
				mac_op   = ACC_W'(err_q) - ACC_W'(elast_q);
				mac_gain = gain_d_q;
			end
		endcase
	end

	mtsp_mac u_mac (
		.acc      (acc_q),
		.op       (mac_op),
		.gain     (mac_gain),
		.bit_idx  (step_q[3:0]),
		.acc_next (mac_next)
	);

	// Drop eight fraction bits toward zero, then clamp to the drive limit; drive is zero when control is off.
	assign acc_mag = acc_q[ACC_W-1] ? -acc_q : acc_q;
	assign acc_shr = acc_q[ACC_W-1] ? -(acc_mag >>> 8) : (acc_mag >>> 8);
	always_comb begin
		if (!en_q) begin
			drive_next = '0;
		end else if (acc_shr > ACC_W'(DRIVE_LIM)) begin
			drive_next = DRIVE_LIM;
		end else if (acc_shr < -ACC_W'(DRIVE_LIM)) begin
			drive_next = -DRIVE_LIM;
		end else begin
			drive_next = DRIVE_W'(acc_shr);
		end
	end

	assign fin_load = (state_q == ST_FIN) && (!out_valid_q || m_axis_tready);

	// ------------------------------------------------------------ sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			ch_q    <= '0;
			armed_q <= 1'b1;
			max_q   <= '{default: '0};
			elast_q <= '0;
			esum_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						raw_q[0] <= s_axis_tdata[SAMPLE_BITS-1:0];
						raw_q[1] <= s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
						raw_q[2] <= s_axis_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
						cal_q    <= s_axis_tuser[0];
						en_q     <= s_axis_tuser[1];
						state_q  <= ST_CAL;
					end
				end
				ST_CAL: begin
					// restart maxima on the first calibrating item, then track
					if (cal_q) begin
						for (int i = 0; i < 3; i++) begin
							if (armed_q || max_q[i] < raw_q[i]) begin
								max_q[i] <= raw_q[i];
							end
						end
						armed_q <= 1'b0;
					end else begin
						armed_q <= 1'b1;
					end
					ch_q    <= '0;
					step_q  <= '0;
					state_q <= ST_RATIO;
				end
				ST_RATIO: begin
					if (step_q == '0) begin
						if (max_q[ch_q] == '0 || raw_q[ch_q] >= max_q[ch_q]) begin
							level_q[ch_q] <= LEVEL_ONE;
							ch_q <= ch_q + 2'd1;
							if (ch_q == 2'd2) begin
								ch_q    <= '0;
								state_q <= ST_SQRT;
							end
						end else begin
							rem_q  <= CSU_W'(raw_q[ch_q]);
							quo_q  <= '0;
							step_q <= STEP_W'(1);
						end
					end else begin
						rem_q  <= rem_next;
						quo_q  <= quo_next;
						step_q <= step_q + STEP_W'(1);
						if (step_q == STEP_W'(RATIO_STEPS)) begin
							level_q[ch_q] <= level_of(RATIO_W'(quo_next[FRAC_BITS-1:0]));
							step_q <= '0;
							ch_q   <= ch_q + 2'd1;
							if (ch_q == 2'd2) begin
								ch_q    <= '0;
								state_q <= ST_SQRT;
							end
						end
					end
				end
				ST_SQRT: begin
					if (step_q == '0) begin
						src_q  <= {sq_in, {(SRC_W-SQ_W){1'b0}}};
						rem_q  <= '0;
						quo_q  <= '0;
						step_q <= STEP_W'(1);
					end else begin
						rem_q  <= rem_next;
						quo_q  <= quo_next;
						src_q  <= src_q << 2;
						step_q <= step_q + STEP_W'(1);
						if (step_q == STEP_W'(ROOT_W)) begin
							root_q[ch_q[0]] <= quo_next[ROOT_W-1:0];
							step_q <= '0;
							ch_q   <= 2'd1;
							if (ch_q == 2'd1) begin
								ch_q    <= '0;
								state_q <= ST_EDIV;
							end
						end
					end
				end
				ST_EDIV: begin
					if (step_q == '0) begin
						src_q  <= {mag, {FRAC_BITS{1'b0}}};
						sum_q  <= SUM_W'(level_q[0]) + SUM_W'(level_q[1]) + SUM_W'(level_q[2]);
						rem_q  <= '0;
						quo_q  <= '0;
						ovf_q  <= 1'b0;
						step_q <= STEP_W'(1);
					end else begin
						rem_q  <= rem_next;
						quo_q  <= quo_next;
						ovf_q  <= ovf_next;
						src_q  <= src_q << 1;
						step_q <= step_q + STEP_W'(1);
						if (step_q == STEP_W'(EDIV_STEPS)) begin
							err_q   <= err_next;
							step_q  <= '0;
							state_q <= ST_PID;
						end
					end
				end
				ST_PID: begin
					if (en_q) begin
						esum_q  <= esum_next;
						acc_q   <= '0;
						ch_q    <= '0;
						step_q  <= '0;
						state_q <= ST_MAC;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_MAC: begin
					acc_q  <= mac_next;
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(GAIN_W - 1)) begin
						step_q <= '0;
						ch_q   <= ch_q + 2'd1;
						if (ch_q == 2'd2) begin
							ch_q    <= '0;
							state_q <= ST_FIN;
						end
					end
				end
				ST_FIN: begin
					if (fin_load) begin
						elast_q <= en_q ? err_q : '0;
						if (!en_q) begin
							esum_q <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ----------------------------------------------------------- result reg
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			for (int i = 0; i < 3; i++) begin
				lvl_out_q[i] <= level_q[i][LEVEL_W-1:FRAC_BITS];
			end
			err_out_q <= err_q;
			drive_q   <= drive_next;
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, drive_q, err_out_q, lvl_out_q[2], lvl_out_q[1], lvl_out_q[0]};

	// ------------------------------------------------------------ assertions
	`MTSP_ASSERT(a_busy_after_transfer, clk, arst_n, s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
	`MTSP_ASSERT(a_drive_in_limit, clk, arst_n, m_axis_tvalid |-> (drive_q <= DRIVE_LIM && drive_q >= -DRIVE_LIM))
	`MTSP_ASSERT(a_off_clears_pid, clk, arst_n, fin_load && !en_q |=> drive_q == '0 && esum_q == '0 && elast_q == '0)

endmodule
